[src/dvaf_pkg.sv]
// Package for the dual vector angle feature block: sizes, command and status
// types, the multiply schedule and the CORDIC arctangent table.
// No dependencies; the other files of the block import it, all but dvaf_if.
package dvaf_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int NUM_LABELS  = 8;
  localparam int COUNT_BITS  = 32;
  localparam int LABEL_W     = 4;
  localparam int LIDX_W      = 3;

  localparam int MOP_W   = 33;            // multiplier operand width
  localparam int PROD_W  = 2 * MOP_W;     // product width
  localparam int MUL_OPS = 18;            // products per word
  localparam int DOT_W   = 34;

  localparam int ACC_W  = 34;             // angle accumulator, LSB pi/2^31
  localparam int ANG_W  = 18;             // rounded angle, LSB pi/2^15
  localparam int KW     = 64;             // CORDIC x and y width

  localparam logic signed [ACC_W-1:0] PI_UNITS  = 34'sd2147483648;
  localparam logic signed [ACC_W-1:0] HALF_LSB  = 34'sd32768;

  typedef enum logic [3:0] {
    SRC_AX, SRC_AY, SRC_AZ, SRC_BX, SRC_BY, SRC_BZ, SRC_CX, SRC_CY, SRC_CZ
  } msrc_e;

  typedef enum logic [3:0] {
    DST_SQA, DST_ZA, DST_SQB, DST_ZB, DST_CX, DST_CY, DST_CZ, DST_DOT, DST_C2
  } mdst_e;

  typedef enum logic [1:0] {
    OP_LOAD, OP_ADD, OP_SUB
  } mop_e;

  typedef struct packed {
    msrc_e a;
    msrc_e b;
    mdst_e dst;
    mop_e  op;
  } mplan_t;

  typedef enum logic [3:0] {
    JOB_MAG_A, JOB_MAG_B, JOB_RXY_A, JOB_ELEV_A, JOB_AZIM_A,
    JOB_RXY_B, JOB_ELEV_B, JOB_AZIM_B, JOB_NORM, JOB_C2, JOB_BETW
  } job_e;

  typedef enum logic [2:0] {
    S_IDLE, S_MUL, S_DRAIN, S_LOAD, S_RUN, S_STORE, S_DONE
  } state_e;

  typedef struct packed {
    logic       item_load;
    logic       mul_go;
    logic [4:0] mul_idx;
    logic       job_load;
    logic       job_step;
    logic       job_store;
    job_e       job;
    logic [4:0] step;
    logic       out_load;
  } cmd_t;

  typedef struct packed {
    logic out_busy;
  } stat_t;

  // Multiply schedule: squares, cross product, dot product, then |a x b|^2.
  function automatic mplan_t mul_plan(input logic [4:0] k);
    mplan_t p;
    p = '{a: SRC_AX, b: SRC_AX, dst: DST_SQA, op: OP_LOAD};
    case (k)
      5'd0:  p = '{a: SRC_AX, b: SRC_AX, dst: DST_SQA, op: OP_LOAD};
      5'd1:  p = '{a: SRC_AY, b: SRC_AY, dst: DST_SQA, op: OP_ADD};
      5'd2:  p = '{a: SRC_AZ, b: SRC_AZ, dst: DST_ZA,  op: OP_LOAD};
      5'd3:  p = '{a: SRC_BX, b: SRC_BX, dst: DST_SQB, op: OP_LOAD};
      5'd4:  p = '{a: SRC_BY, b: SRC_BY, dst: DST_SQB, op: OP_ADD};
      5'd5:  p = '{a: SRC_BZ, b: SRC_BZ, dst: DST_ZB,  op: OP_LOAD};
      5'd6:  p = '{a: SRC_AY, b: SRC_BZ, dst: DST_CX,  op: OP_LOAD};
      5'd7:  p = '{a: SRC_AZ, b: SRC_BY, dst: DST_CX,  op: OP_SUB};
      5'd8:  p = '{a: SRC_AZ, b: SRC_BX, dst: DST_CY,  op: OP_LOAD};
      5'd9:  p = '{a: SRC_AX, b: SRC_BZ, dst: DST_CY,  op: OP_SUB};
      5'd10: p = '{a: SRC_AX, b: SRC_BY, dst: DST_CZ,  op: OP_LOAD};
      5'd11: p = '{a: SRC_AY, b: SRC_BX, dst: DST_CZ,  op: OP_SUB};
      5'd12: p = '{a: SRC_AX, b: SRC_BX, dst: DST_DOT, op: OP_LOAD};
      5'd13: p = '{a: SRC_AY, b: SRC_BY, dst: DST_DOT, op: OP_ADD};
      5'd14: p = '{a: SRC_AZ, b: SRC_BZ, dst: DST_DOT, op: OP_ADD};
      5'd15: p = '{a: SRC_CX, b: SRC_CX, dst: DST_C2,  op: OP_LOAD};
      5'd16: p = '{a: SRC_CY, b: SRC_CY, dst: DST_C2,  op: OP_ADD};
      5'd17: p = '{a: SRC_CZ, b: SRC_CZ, dst: DST_C2,  op: OP_ADD};
      default: p = '{a: SRC_AX, b: SRC_AX, dst: DST_SQA, op: OP_LOAD};
    endcase
    return p;
  endfunction

  // Iterations of each job: root bits for square roots, normalisation steps, steps for CORDIC.
  function automatic logic [5:0] job_len(input job_e j);
    logic [5:0] n;
    case (j)
      JOB_MAG_A, JOB_MAG_B, JOB_NORM: n = 6'd16;
      JOB_C2:                         n = 6'd32;
      default:                        n = 6'd24;
    endcase
    return n;
  endfunction

  function automatic logic signed [ACC_W-1:0] atan_lut(input logic [4:0] i);
    logic signed [ACC_W-1:0] v;
    case (i)
      5'd0:  v = 34'sd536870912;
      5'd1:  v = 34'sd316933406;
      5'd2:  v = 34'sd167458907;
      5'd3:  v = 34'sd85004756;
      5'd4:  v = 34'sd42667331;
      5'd5:  v = 34'sd21354465;
      5'd6:  v = 34'sd10679838;
      5'd7:  v = 34'sd5340245;
      5'd8:  v = 34'sd2670163;
      5'd9:  v = 34'sd1335087;
      5'd10: v = 34'sd667544;
      5'd11: v = 34'sd333772;
      5'd12: v = 34'sd166886;
      5'd13: v = 34'sd83443;
      5'd14: v = 34'sd41722;
      5'd15: v = 34'sd20861;
      5'd16: v = 34'sd10430;
      5'd17: v = 34'sd5215;
      5'd18: v = 34'sd2608;
      5'd19: v = 34'sd1304;
      5'd20: v = 34'sd652;
      5'd21: v = 34'sd326;
      5'd22: v = 34'sd163;
      5'd23: v = 34'sd81;
      default: v = '0;
    endcase
    return v;
  endfunction

  function automatic logic [15:0] sat16(input logic signed [ANG_W-1:0] v,
                                        input logic signed [ANG_W-1:0] lo,
                                        input logic signed [ANG_W-1:0] hi);
    logic signed [ANG_W-1:0] r;
    r = (v < lo) ? lo : ((v > hi) ? hi : v);
    return r[15:0];
  endfunction

endpackage

[src/dvaf_if.sv]
// Valid/ready channel interfaces of the dual vector angle feature block:
// one for input words and one for result words. No dependencies.
interface dvaf_in_if;
  logic               valid;
  logic               ready;
  logic [3:0]         label;
  logic signed [15:0] ax;
  logic signed [15:0] ay;
  logic signed [15:0] az;
  logic signed [15:0] bx;
  logic signed [15:0] by_comp;
  logic signed [15:0] bz;

  modport source (output valid, label, ax, ay, az, bx, by_comp, bz, input ready);
  modport sink (input valid, label, ax, ay, az, bx, by_comp, bz, output ready);
endinterface

interface dvaf_out_if;
  logic               valid;
  logic               ready;
  logic [3:0]         label_out;
  logic [15:0]        mag_a;
  logic [15:0]        mag_b;
  logic signed [15:0] elev_a;
  logic signed [15:0] azim_a;
  logic signed [15:0] elev_b;
  logic signed [15:0] azim_b;
  logic [15:0]        between;
  logic [31:0]        label_count;
  logic [31:0]        total_count;

  modport source (output valid, label_out, mag_a, mag_b, elev_a, azim_a, elev_b,
                  azim_b, between, label_count, total_count, input ready);
  modport sink (input valid, label_out, mag_a, mag_b, elev_a, azim_a, elev_b,
                azim_b, between, label_count, total_count, output ready);
endinterface

[src/dual_vector_angle_features.sv]
// Top level of the dual vector angle feature block: sequencer plus datapath.
// Depends on dvaf_pkg, dvaf_if, dvaf_ctrl and dvaf_dp.
//
// Each input word carries a class label and two signed 3-axis vectors; the
// block returns one result word with both magnitudes, elevation and azimuth
// of each vector (full-circle for the first, half-plane for the second), the
// angle between the vectors and the running label and total counts. Words are
// handled one at a time: 18 products on the single 33 by 33 bit multiplier
// plus a drain state, then eleven jobs of a load, their iterations and a
// store, the iterations being 16, 24 or 32 root bits for the square roots,
// 16 normalisation steps and 24 steps for each CORDIC angle, and a last
// state to place the word in the result register. The result register frees
// the input side, so a new word is taken on the cycle after the previous one
// has been placed there, even when the consumer has not yet taken it. A
// result word still waiting on the consumer holds the finished word back
// until the consumer takes it.
module dual_vector_angle_features import dvaf_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  dvaf_in_if.sink    in_i,
  dvaf_out_if.source res_o
);

  cmd_t  cmd;
  stat_t stat;

  // The sequencer owns the input handshake and steps the datapath.
  dvaf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // The datapath holds the word, the arithmetic units and the result word.
  dvaf_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .label_i       (in_i.label),
    .ax_i          (in_i.ax),
    .ay_i          (in_i.ay),
    .az_i          (in_i.az),
    .bx_i          (in_i.bx),
    .by_comp_i     (in_i.by_comp),
    .bz_i          (in_i.bz),
    .res_ready_i   (res_o.ready),
    .res_valid_o   (res_o.valid),
    .label_out_o   (res_o.label_out),
    .mag_a_o       (res_o.mag_a),
    .mag_b_o       (res_o.mag_b),
    .elev_a_o      (res_o.elev_a),
    .azim_a_o      (res_o.azim_a),
    .elev_b_o      (res_o.elev_b),
    .azim_b_o      (res_o.azim_b),
    .between_o     (res_o.between),
    .label_count_o (res_o.label_count),
    .total_count_o (res_o.total_count)
  );

  // Once a word is taken, no further word is taken on the next cycle.
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready |=> !in_i.ready)
    else $error("second word accepted while one is in progress");

  // The angle between the vectors never exceeds pi.
  a_between_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid |-> res_o.between <= 16'd32768)
    else $error("angle between vectors out of range");

  // Labels outside the counted range report a zero count.
  a_label_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && (res_o.label_out == 4'd0 || res_o.label_out > 4'd8)
    |-> res_o.label_count == 32'd0)
    else $error("uncounted label reports a non-zero count");

endmodule

[src/dvaf_ctrl.sv]
// Sequencer of the dual vector angle feature block: walks the multiply
// schedule and then each square-root, normalise and CORDIC job. Uses dvaf_pkg.
module dvaf_ctrl import dvaf_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  stat_t stat_i,
  output cmd_t  cmd_o
);

  state_e     state_q, state_d;
  job_e       job_q, job_d;
  logic [5:0] cnt_q, cnt_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      job_q   <= JOB_MAG_A;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      job_q   <= job_d;
      cnt_q   <= cnt_d;
    end
  end

  always_comb begin
    state_d       = state_q;
    job_d         = job_q;
    cnt_d         = cnt_q;
    in_ready_o    = 1'b0;
    cmd_o         = '0;
    cmd_o.job     = job_q;
    cmd_o.mul_idx = cnt_q[4:0];
    cmd_o.step    = cnt_q[4:0];
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.item_load = 1'b1;
          cnt_d           = '0;
          state_d         = S_MUL;
        end
      end
      S_MUL: begin
        cmd_o.mul_go = 1'b1;
        if (cnt_q == 6'(MUL_OPS - 1)) begin
          state_d = S_DRAIN;
        end else begin
          cnt_d = cnt_q + 6'd1;
        end
      end
      S_DRAIN: begin
        job_d   = JOB_MAG_A;
        state_d = S_LOAD;
      end
      S_LOAD: begin
        cmd_o.job_load = 1'b1;
        cnt_d          = '0;
        state_d        = S_RUN;
      end
      S_RUN: begin
        cmd_o.job_step = 1'b1;
        if (cnt_q == job_len(job_q) - 6'd1) begin
          state_d = S_STORE;
        end else begin
          cnt_d = cnt_q + 6'd1;
        end
      end
      S_STORE: begin
        cmd_o.job_store = 1'b1;
        if (job_q == JOB_BETW) begin
          state_d = S_DONE;
        end else begin
          job_d   = job_e'(job_q + 4'd1);
          state_d = S_LOAD;
        end
      end
      S_DONE: begin
        if (!stat_i.out_busy) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

[src/dvaf_dp.sv]
// Datapath of the dual vector angle feature block: shared multiplier with
// accumulators, bit-serial square root, CORDIC, counters and result register.
// Uses dvaf_pkg; driven by dvaf_ctrl.
module dvaf_dp import dvaf_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cmd_t               cmd_i,
  output stat_t              stat_o,
  input  logic [3:0]         label_i,
  input  logic signed [15:0] ax_i,
  input  logic signed [15:0] ay_i,
  input  logic signed [15:0] az_i,
  input  logic signed [15:0] bx_i,
  input  logic signed [15:0] by_comp_i,
  input  logic signed [15:0] bz_i,
  input  logic               res_ready_i,
  output logic               res_valid_o,
  output logic [3:0]         label_out_o,
  output logic [15:0]        mag_a_o,
  output logic [15:0]        mag_b_o,
  output logic [15:0]        elev_a_o,
  output logic [15:0]        azim_a_o,
  output logic [15:0]        elev_b_o,
  output logic [15:0]        azim_b_o,
  output logic [15:0]        between_o,
  output logic [31:0]        label_count_o,
  output logic [31:0]        total_count_o
);

  // Item registers.
  logic [3:0]         label_q;
  logic signed [15:0] ax_q, ay_q, az_q, bx_q, by_q, bz_q;

  // Multiplier and accumulators.
  mplan_t                    plan;
  logic signed [MOP_W-1:0]   mop_a, mop_b;
  logic signed [PROD_W-1:0]  prod_d, prod_q, acc_cur, acc_new;
  logic                      pend_q;
  mdst_e                     pdst_q;
  mop_e                      pop_q;
  logic [31:0]               sqa_q, za_q, sqb_q, zb_q;
  logic signed [MOP_W-1:0]   cx_q, cy_q, cz_q;
  logic signed [DOT_W-1:0]   dot_q;
  logic [63:0]               c2_q, ad_q;
  logic                      dneg_q;

  // Square root unit.
  logic [63:0] sop_q;
  logic [35:0] srem_q, rem_sh, trial;
  logic [31:0] sroot_q;
  logic [32:0] na, nb;

  // CORDIC unit.
  logic signed [KW-1:0]    kx_q, ky_q, kx0, ky0, kdx, kdy;
  logic signed [ACC_W-1:0] kacc_q, kacc0, ksum;
  logic                    kfull;
  logic signed [ANG_W-1:0] ang;
  logic [23:0]             rxy_q;
  logic [31:0]             rc_q;

  // Staged results.
  logic [15:0] mag_a_q, mag_b_q, elev_a_q, azim_a_q, elev_b_q, azim_b_q, betw_q;

  // Counters and result register.
  logic [COUNT_BITS-1:0] cnt_q [NUM_LABELS];
  logic [COUNT_BITS-1:0] tot_q, cnt_inc, tot_inc;
  logic                  lbl_ok;
  logic [LIDX_W-1:0]     lidx;
  logic                  res_valid_q;
  logic [3:0]            res_label_q;
  logic [15:0]           res_mag_a_q, res_mag_b_q, res_elev_a_q, res_azim_a_q;
  logic [15:0]           res_elev_b_q, res_azim_b_q, res_betw_q;
  logic [31:0]           res_lcnt_q, res_tot_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.item_load) begin
      label_q <= label_i;
      ax_q    <= ax_i;
      ay_q    <= ay_i;
      az_q    <= az_i;
      bx_q    <= bx_i;
      by_q    <= by_comp_i;
      bz_q    <= bz_i;
    end
  end

  // ---- multiply and accumulate ----
  assign plan = mul_plan(cmd_i.mul_idx);

  always_comb begin
    case (plan.a)
      SRC_AX:  mop_a = MOP_W'(ax_q);
      SRC_AY:  mop_a = MOP_W'(ay_q);
      SRC_AZ:  mop_a = MOP_W'(az_q);
      SRC_BX:  mop_a = MOP_W'(bx_q);
      SRC_BY:  mop_a = MOP_W'(by_q);
      SRC_BZ:  mop_a = MOP_W'(bz_q);
      SRC_CX:  mop_a = cx_q;
      SRC_CY:  mop_a = cy_q;
      SRC_CZ:  mop_a = cz_q;
      default: mop_a = '0;
    endcase
    case (plan.b)
      SRC_AX:  mop_b = MOP_W'(ax_q);
      SRC_AY:  mop_b = MOP_W'(ay_q);
      SRC_AZ:  mop_b = MOP_W'(az_q);
      SRC_BX:  mop_b = MOP_W'(bx_q);
      SRC_BY:  mop_b = MOP_W'(by_q);
      SRC_BZ:  mop_b = MOP_W'(bz_q);
      SRC_CX:  mop_b = cx_q;
      SRC_CY:  mop_b = cy_q;
      SRC_CZ:  mop_b = cz_q;
      default: mop_b = '0;
    endcase
  end

  assign prod_d = PROD_W'(mop_a) * PROD_W'(mop_b);

  always_comb begin
    case (pdst_q)
      DST_SQA: acc_cur = PROD_W'({1'b0, sqa_q});
      DST_ZA:  acc_cur = PROD_W'({1'b0, za_q});
      DST_SQB: acc_cur = PROD_W'({1'b0, sqb_q});
      DST_ZB:  acc_cur = PROD_W'({1'b0, zb_q});
      DST_CX:  acc_cur = PROD_W'(cx_q);
      DST_CY:  acc_cur = PROD_W'(cy_q);
      DST_CZ:  acc_cur = PROD_W'(cz_q);
      DST_DOT: acc_cur = PROD_W'(dot_q);
      DST_C2:  acc_cur = PROD_W'({1'b0, c2_q});
      default: acc_cur = '0;
    endcase
    case (pop_q)
      OP_LOAD: acc_new = prod_q;
      OP_ADD:  acc_new = acc_cur + prod_q;
      OP_SUB:  acc_new = acc_cur - prod_q;
      default: acc_new = prod_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 1'b0;
    end else begin
      pend_q <= cmd_i.mul_go;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_go) begin
      prod_q <= prod_d;
      pdst_q <= plan.dst;
      pop_q  <= plan.op;
    end
  end

  // The squared norm of |a x b| is scaled up with the dot product while both
  // keep their headroom.
  always_ff @(posedge clk_i) begin
    if (pend_q) begin
      case (pdst_q)
        DST_SQA: sqa_q <= acc_new[31:0];
        DST_ZA:  za_q  <= acc_new[31:0];
        DST_SQB: sqb_q <= acc_new[31:0];
        DST_ZB:  zb_q  <= acc_new[31:0];
        DST_CX:  cx_q  <= acc_new[MOP_W-1:0];
        DST_CY:  cy_q  <= acc_new[MOP_W-1:0];
        DST_CZ:  cz_q  <= acc_new[MOP_W-1:0];
        DST_DOT: dot_q <= acc_new[DOT_W-1:0];
        DST_C2:  c2_q  <= acc_new[63:0];
        default: ;
      endcase
    end else if (cmd_i.job_load && cmd_i.job == JOB_NORM) begin
      ad_q   <= dot_q[DOT_W-1] ? 64'(-dot_q) : 64'(dot_q);
      dneg_q <= dot_q[DOT_W-1];
    end else if (cmd_i.job_step && cmd_i.job == JOB_NORM) begin
      if (c2_q[63:62] == 2'b00 && ad_q[63:60] == 4'b0000) begin
        c2_q <= {c2_q[61:0], 2'b00};
        ad_q <= {ad_q[62:0], 1'b0};
      end
    end
  end

  // ---- square root, one root bit a cycle ----
  assign na     = {1'b0, sqa_q} + {1'b0, za_q};
  assign nb     = {1'b0, sqb_q} + {1'b0, zb_q};
  assign rem_sh = {srem_q[33:0], sop_q[63:62]};
  assign trial  = {2'b00, sroot_q, 2'b01};

  always_ff @(posedge clk_i) begin
    if (cmd_i.job_load) begin
      srem_q  <= '0;
      sroot_q <= '0;
      case (cmd_i.job)
        JOB_MAG_A: sop_q <= {na[31:0], 32'd0};
        JOB_MAG_B: sop_q <= {nb[31:0], 32'd0};
        JOB_RXY_A: sop_q <= {sqa_q, 32'd0};
        JOB_RXY_B: sop_q <= {sqb_q, 32'd0};
        default:   sop_q <= c2_q;
      endcase
    end else if (cmd_i.job_step) begin
      sop_q <= {sop_q[61:0], 2'b00};
      if (rem_sh >= trial) begin
        srem_q  <= rem_sh - trial;
        sroot_q <= {sroot_q[30:0], 1'b1};
      end else begin
        srem_q  <= rem_sh;
        sroot_q <= {sroot_q[30:0], 1'b0};
      end
    end
  end

  // ---- CORDIC in vectoring mode ----
  always_comb begin
    kfull = 1'b1;
    case (cmd_i.job)
      JOB_ELEV_A: begin
        ky0 = {{40{az_q[15]}}, az_q, 8'd0};
        kx0 = {40'd0, rxy_q};
      end
      JOB_AZIM_A: begin
        ky0 = KW'(ay_q);
        kx0 = KW'(ax_q);
      end
      JOB_ELEV_B: begin
        ky0 = {{40{bz_q[15]}}, bz_q, 8'd0};
        kx0 = {40'd0, rxy_q};
      end
      JOB_AZIM_B: begin
        ky0   = KW'(by_q);
        kx0   = KW'(bx_q);
        kfull = 1'b0;
      end
      default: begin
        ky0 = {32'd0, rc_q};
        kx0 = dneg_q ? -ad_q : ad_q;
      end
    endcase
    if (kx0[KW-1] && kfull) begin
      kacc0 = ky0[KW-1] ? -PI_UNITS : PI_UNITS;
    end else begin
      kacc0 = '0;
    end
  end

  assign kdx  = ky_q >>> cmd_i.step;
  assign kdy  = kx_q >>> cmd_i.step;
  assign ksum = kacc_q + HALF_LSB;
  assign ang  = ANG_W'(ksum >>> 16);

  always_ff @(posedge clk_i) begin
    if (cmd_i.job_load) begin
      kacc_q <= kacc0;
      if (kx0[KW-1]) begin
        kx_q <= -kx0;
        ky_q <= -ky0;
      end else begin
        kx_q <= kx0;
        ky_q <= ky0;
      end
    end else if (cmd_i.job_step) begin
      if (ky_q[KW-1]) begin
        kx_q   <= kx_q - kdx;
        ky_q   <= ky_q + kdy;
        kacc_q <= kacc_q - atan_lut(cmd_i.step);
      end else begin
        kx_q   <= kx_q + kdx;
        ky_q   <= ky_q - kdy;
        kacc_q <= kacc_q + atan_lut(cmd_i.step);
      end
    end
  end

  // ---- job results ----
  always_ff @(posedge clk_i) begin
    if (cmd_i.job_store) begin
      case (cmd_i.job)
        JOB_MAG_A:  mag_a_q <= sroot_q[15:0];
        JOB_MAG_B:  mag_b_q <= sroot_q[15:0];
        JOB_RXY_A,
        JOB_RXY_B:  rxy_q   <= sroot_q[23:0];
        JOB_C2:     rc_q    <= sroot_q;
        JOB_ELEV_A: elev_a_q <= (ax_q == '0) ? '0 : sat16(ang, -18'sd16384, 18'sd16384);
        JOB_AZIM_A: azim_a_q <= (ax_q == '0) ? '0 : sat16(ang, -18'sd32768, 18'sd32768);
        JOB_ELEV_B: elev_b_q <= (bx_q == '0) ? '0 : sat16(ang, -18'sd16384, 18'sd16384);
        JOB_AZIM_B: azim_b_q <= (bx_q == '0) ? '0 : sat16(ang, -18'sd16384, 18'sd16384);
        JOB_BETW:   betw_q <= (na == '0 || nb == '0) ? '0 : sat16(ang, 18'sd0, 18'sd32768);
        default: ;
      endcase
    end
  end

  // ---- label counters and result register ----
  assign lbl_ok  = (label_q != '0) && ({1'b0, label_q} <= 5'(NUM_LABELS));
  assign lidx    = LIDX_W'(label_q - 4'd1);
  assign cnt_inc = cnt_q[lidx] + 1'b1;
  assign tot_inc = tot_q + 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tot_q       <= '0;
      res_valid_q <= 1'b0;
      for (int i = 0; i < NUM_LABELS; i++) begin
        cnt_q[i] <= '0;
      end
    end else begin
      if (cmd_i.out_load) begin
        tot_q       <= tot_inc;
        res_valid_q <= 1'b1;
        if (lbl_ok) begin
          cnt_q[lidx] <= cnt_inc;
        end
      end else if (res_ready_i) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      res_label_q  <= label_q;
      res_mag_a_q  <= mag_a_q;
      res_mag_b_q  <= mag_b_q;
      res_elev_a_q <= elev_a_q;
      res_azim_a_q <= azim_a_q;
      res_elev_b_q <= elev_b_q;
      res_azim_b_q <= azim_b_q;
      res_betw_q   <= betw_q;
      res_lcnt_q   <= lbl_ok ? 32'(cnt_inc) : '0;
      res_tot_q    <= 32'(tot_inc);
    end
  end

  assign stat_o.out_busy = res_valid_q && !res_ready_i;
  assign res_valid_o     = res_valid_q;
  assign label_out_o     = res_label_q;
  assign mag_a_o         = res_mag_a_q;
  assign mag_b_o         = res_mag_b_q;
  assign elev_a_o        = res_elev_a_q;
  assign azim_a_o        = res_azim_a_q;
  assign elev_b_o        = res_elev_b_q;
  assign azim_b_o        = res_azim_b_q;
  assign between_o       = res_betw_q;
  assign label_count_o   = res_lcnt_q;
  assign total_count_o   = res_tot_q;

endmodule

[dv/dual_vector_angle_features_tb.sv]
// Self-checking testbench for dual_vector_angle_features: drives input words,
// predicts every result word and compares it field by field.
// Depends on dvaf_pkg, dvaf_if and the block's RTL.
`timescale 1ns / 1ps

module dual_vector_angle_features_tb;
  import dvaf_pkg::*;

  // Binary angle of pi in accumulator units (pi/2^31).
  localparam longint HALF_TURN = 64'sd2147483648;
  localparam int     ROT_STEPS = 24;
  // Generous ceiling on how long any single word may take, in cycles.
  localparam int     WORD_CYCLES = 300;

  // Arctangent of 2^-i in accumulator units, one entry per rotation.
  localparam longint ROT_ANGLE [ROT_STEPS] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772,
    166886, 83443, 41722, 20861, 10430, 5215,
    2608, 1304, 652, 326, 163, 81
  };

  typedef struct packed {
    logic [3:0]         label;
    logic signed [15:0] ax, ay, az, bx, by_comp, bz;
  } sample_t;

  typedef struct packed {
    logic [3:0]  label_out;
    logic [15:0] mag_a, mag_b, elev_a, azim_a, elev_b, azim_b, between;
    logic [31:0] label_count, total_count;
  } features_t;

  logic clk_i;
  logic rst_ni;

  dvaf_in_if  in_ch ();
  dvaf_out_if res_ch ();

  dual_vector_angle_features DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch.sink),
    .res_o (res_ch.source)
  );

  // Predictor state: a copy of the block's label and total counters.
  logic [31:0] class_tally [1:NUM_LABELS];
  logic [31:0] word_tally;

  features_t pending_features [$];
  int        error_count;
  int        words_sent;
  int        words_checked;
  bit        steady;   // set for the last part of the run: no idling at all

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Floor square root, bit by bit from the top.
  function automatic longint unsigned floor_root(input longint unsigned n);
    longint unsigned r, t;
    r = 0;
    for (int b = 31; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if (t * t <= n) r = t;
    end
    return r;
  endfunction

  // Vectoring CORDIC: angle of (x, y) rounded to pi/32768. When full is
  // clear, a negative x folds the vector through the origin (plain atan).
  function automatic longint vector_angle(input longint y, input longint x,
                                          input bit full);
    longint acc, dx, dy;
    acc = 0;
    if (x < 0) begin
      if (full) acc = (y >= 0) ? HALF_TURN : -HALF_TURN;
      x = -x;
      y = -y;
    end
    for (int i = 0; i < ROT_STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y < 0) begin
        x -= dx;
        y += dy;
        acc -= ROT_ANGLE[i];
      end else begin
        x += dx;
        y -= dy;
        acc += ROT_ANGLE[i];
      end
    end
    return (acc + 32768) >>> 16;
  endfunction

  function automatic longint clip(input longint v, input longint lo, input longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // Elevation and azimuth of one vector; both are zero when x is zero.
  function automatic void spherical(input longint x, input longint y, input longint z,
                                    input bit full, output longint elev,
                                    output longint azim);
    longint unsigned sq;
    longint rxy;
    elev = 0;
    azim = 0;
    if (x != 0) begin
      sq   = longint'(x * x + y * y);
      rxy  = longint'(floor_root(sq << 16));
      elev = clip(vector_angle(z * 256, rxy, 1'b1), -16384, 16384);
      if (full) azim = clip(vector_angle(y, x, 1'b1), -32768, 32768);
      else      azim = clip(vector_angle(y, x, 1'b0), -16384, 16384);
    end
  endfunction

  // Works out the result word for one accepted sample and advances the counters.
  function automatic features_t predict_features(input sample_t s);
    features_t f;
    longint ax, ay, az, bx, by, bz, cx, cy, cz, dot;
    longint ea, aa, eb, ab, betw;
    longint unsigned na, nb, c2, ad, root_a, root_b;
    int sh;
    ax = s.ax; ay = s.ay; az = s.az;
    bx = s.bx; by = s.by_comp; bz = s.bz;
    na = ax * ax + ay * ay + az * az;
    nb = bx * bx + by * by + bz * bz;
    spherical(ax, ay, az, 1'b1, ea, aa);
    spherical(bx, by, bz, 1'b0, eb, ab);
    betw = 0;
    if (na != 0 && nb != 0) begin
      cx  = ay * bz - az * by;
      cy  = az * bx - ax * bz;
      cz  = ax * by - ay * bx;
      dot = ax * bx + ay * by + az * bz;
      c2  = cx * cx + cy * cy + cz * cz;
      ad  = (dot < 0) ? -dot : dot;
      // Scale a small cross product and the dot product up together.
      sh = 0;
      while (sh < 16 && c2 < (64'd1 << 62) && ad < (64'd1 << 60)) begin
        c2 = c2 << 2;
        ad = ad << 1;
        sh++;
      end
      dot  = (dot < 0) ? -longint'(ad) : longint'(ad);
      betw = clip(vector_angle(longint'(floor_root(c2)), dot, 1'b1), 0, 32768);
    end
    word_tally = word_tally + 1;
    f.label_count = '0;
    if (s.label >= 1 && s.label <= NUM_LABELS) begin
      class_tally[s.label] = class_tally[s.label] + 1;
      f.label_count = class_tally[s.label];
    end
    root_a        = floor_root(na);
    root_b        = floor_root(nb);
    f.label_out   = s.label;
    f.mag_a       = root_a[15:0];
    f.mag_b       = root_b[15:0];
    f.elev_a      = ea[15:0];
    f.azim_a      = aa[15:0];
    f.elev_b      = eb[15:0];
    f.azim_b      = ab[15:0];
    f.between     = betw[15:0];
    f.total_count = word_tally;
    return f;
  endfunction

  // Sends one sample, holding it until the block takes it. Between words the
  // source may go quiet for a short random burst.
  task automatic send_sample(input sample_t s);
    @(negedge clk_i);
    if (!steady && $urandom_range(0, 3) == 0) begin
      in_ch.valid = 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk_i);
    end
    in_ch.valid   = 1'b1;
    in_ch.label   = s.label;
    in_ch.ax      = s.ax;
    in_ch.ay      = s.ay;
    in_ch.az      = s.az;
    in_ch.bx      = s.bx;
    in_ch.by_comp = s.by_comp;
    in_ch.bz      = s.bz;
    do @(posedge clk_i); while (!in_ch.ready);
    pending_features.push_back(predict_features(s));
    words_sent++;
  endtask

  function automatic sample_t make_sample(input int lab, input int ax, input int ay,
                                          input int az, input int bx, input int by,
                                          input int bz);
    sample_t s;
    s.label = 4'(lab); s.ax = 16'(ax); s.ay = 16'(ay); s.az = 16'(az);
    s.bx = 16'(bx); s.by_comp = 16'(by); s.bz = 16'(bz);
    return s;
  endfunction

  function automatic logic signed [15:0] any_axis();
    case ($urandom_range(0, 5))
      0:       return 16'sh8000;
      1:       return 16'sh7fff;
      2:       return 16'(int'($urandom_range(0, 16)) - 8);
      default: return 16'($urandom);
    endcase
  endfunction

  // Full-scale corners of both vectors, labels inside and outside the counted range.
  task automatic test_extremes();
    send_sample(make_sample(0, 32767, 32767, 32767, 32767, 32767, 32767));
    send_sample(make_sample(15, -32768, -32768, -32768, -32768, -32768, -32768));
    send_sample(make_sample(1, -32768, 32767, -32768, 32767, -32768, 32767));
    send_sample(make_sample(8, 32767, -32768, 32767, -32768, 32767, -32768));
    send_sample(make_sample(9, 1, -1, 1, -1, 1, -1));
    send_sample(make_sample(4, 'h5555, 'haaaa, 'h5555, 'haaaa, 'h5555, 'haaaa));
    send_sample(make_sample(5, 'haaaa, 'h5555, 'haaaa, 'h5555, 'haaaa, 'h5555));
  endtask

  // Zero x hides a vector's angles; an all-zero vector hides the angle between.
  task automatic test_zero_cases();
    send_sample(make_sample(2, 0, 1000, -2000, 0, -3000, 500));
    send_sample(make_sample(3, 0, 0, 0, 1200, 300, -40));
    send_sample(make_sample(6, 700, -20, 9, 0, 0, 0));
    send_sample(make_sample(7, 0, 0, 0, 0, 0, 0));
  endtask

  // Azimuth exactly at pi wraps, negative x on the second vector folds, and
  // nearly parallel or opposite vectors exercise the cross product scaling.
  task automatic test_angle_corners();
    send_sample(make_sample(1, -5, 0, 0, -5, 0, 0));
    send_sample(make_sample(1, -32768, 0, 3, -1, 0, 0));
    send_sample(make_sample(2, -100, -1, 0, -100, 7, -9));
    send_sample(make_sample(3, -300, 300, 12, -20000, -20000, 30000));
    send_sample(make_sample(4, 1000, 1000, 1000, 2000, 2000, 2001));
    send_sample(make_sample(5, 1, 0, 0, 32767, 1, 0));
    send_sample(make_sample(6, 12345, -321, 77, -12345, 321, -77));
    send_sample(make_sample(8, 3, 4, 0, 0, 5, 1));
    send_sample(make_sample(0, 32767, 0, -32768, -32768, 0, 32767));
  endtask

  // Random words: mostly arbitrary vectors, with small and extreme axes mixed in
  // and now and then a zero x or a vector parallel or opposite to the first.
  task automatic test_random(input int count);
    sample_t s;
    for (int n = 0; n < count; n++) begin
      if (n == count - count / 5) steady = 1'b1;
      s = make_sample($urandom_range(0, 15), any_axis(), any_axis(), any_axis(),
                      any_axis(), any_axis(), any_axis());
      case ($urandom_range(0, 9))
        0: s.ax = '0;
        1: s.bx = '0;
        2: begin
          s.bx = s.ax >>> 1; s.by_comp = s.ay >>> 1; s.bz = s.az >>> 1;
        end
        3: begin
          s.bx = -(s.ax >>> 1); s.by_comp = -(s.ay >>> 1); s.bz = -(s.az >>> 1);
        end
        default: ;
      endcase
      send_sample(s);
    end
  endtask

  // Result side: ready drops for random bursts until the quiet last part.
  always @(negedge clk_i) begin
    if (!steady && $urandom_range(0, 4) == 0) begin
      res_ch.ready = 1'b0;
      repeat ($urandom_range(1, 3) - 1) @(negedge clk_i);
    end else begin
      res_ch.ready = 1'b1;
    end
  end

  // Compares every accepted result word with the oldest prediction.
  always @(posedge clk_i) begin
    features_t want;
    if (rst_ni && res_ch.valid && res_ch.ready) begin
      if (pending_features.size() == 0) begin
        $error("result word arrived with no prediction waiting");
        error_count++;
      end else begin
        want = pending_features.pop_front();
        words_checked++;
        if (res_ch.label_out !== want.label_out) begin
          $error("label_out: expected %0d, got %0d", want.label_out, res_ch.label_out);
          error_count++;
        end
        if (res_ch.mag_a !== want.mag_a) begin
          $error("mag_a: expected %0d, got %0d", want.mag_a, res_ch.mag_a);
          error_count++;
        end
        if (res_ch.mag_b !== want.mag_b) begin
          $error("mag_b: expected %0d, got %0d", want.mag_b, res_ch.mag_b);
          error_count++;
        end
        if (res_ch.elev_a !== want.elev_a) begin
          $error("elev_a: expected %0d, got %0d", $signed(want.elev_a), res_ch.elev_a);
          error_count++;
        end
        if (res_ch.azim_a !== want.azim_a) begin
          $error("azim_a: expected %0d, got %0d", $signed(want.azim_a), res_ch.azim_a);
          error_count++;
        end
        if (res_ch.elev_b !== want.elev_b) begin
          $error("elev_b: expected %0d, got %0d", $signed(want.elev_b), res_ch.elev_b);
          error_count++;
        end
        if (res_ch.azim_b !== want.azim_b) begin
          $error("azim_b: expected %0d, got %0d", $signed(want.azim_b), res_ch.azim_b);
          error_count++;
        end
        if (res_ch.between !== want.between) begin
          $error("between: expected %0d, got %0d", want.between, res_ch.between);
          error_count++;
        end
        if (res_ch.label_count !== want.label_count) begin
          $error("label_count: expected %0d, got %0d", want.label_count,
                 res_ch.label_count);
          error_count++;
        end
        if (res_ch.total_count !== want.total_count) begin
          $error("total_count: expected %0d, got %0d", want.total_count,
                 res_ch.total_count);
          error_count++;
        end
      end
    end
  end

  // Overall time limit: far beyond 1520 words at their slowest with all stalls.
  initial begin
    #20ms;
    $display("tb: failure");
    $finish;
  end

  initial begin
    steady        = 1'b0;
    error_count   = 0;
    words_sent    = 0;
    words_checked = 0;
    word_tally    = '0;
    for (int i = 1; i <= NUM_LABELS; i++) class_tally[i] = '0;
    in_ch.valid   = 1'b0;
    in_ch.label   = '0;
    in_ch.ax      = '0;
    in_ch.ay      = '0;
    in_ch.az      = '0;
    in_ch.bx      = '0;
    in_ch.by_comp = '0;
    in_ch.bz      = '0;
    res_ch.ready  = 1'b0;
    rst_ni        = 1'b0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_extremes();
    test_zero_cases();
    test_angle_corners();
    test_random(1500);

    @(negedge clk_i);
    in_ch.valid = 1'b0;
    while (pending_features.size() != 0) @(posedge clk_i);
    repeat (WORD_CYCLES) @(posedge clk_i);

    $display("Checked %0d of %0d words: extreme axes, zero x and zero vectors,",
             words_checked, words_sent);
    $display("azimuth at pi, folded half-plane, near-parallel vectors, all labels.");
    if (error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
